FILE: hdl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
`default_nettype none

package spq_pkg;

  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;

  localparam logic signed [DATA_W-1:0] EMPTY_DATA = -32'sd1;

  // Request codes; the unused code is served as a read of the front entry
  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_HOLD = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    exec;
    logic    push;
    logic    pop;
    status_t rsp_status;
  } spq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } spq_stat_t;

endpackage

`default_nettype wire

FILE: hdl/spq_in_if.sv
// Request channel: valid/ready handshake with the request payload.
`default_nettype none

interface spq_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          req_type;
  logic signed [spq_pkg::DATA_W-1:0]   item_data;
  logic signed [spq_pkg::DATA_W-1:0]   item_priority;

  modport source (output valid, req_type, item_data, item_priority, input ready);
  modport sink   (input valid, req_type, item_data, item_priority, output ready);
endinterface

`default_nettype wire

FILE: hdl/spq_out_if.sv
// Response channel: valid/ready handshake with the response payload.
`default_nettype none

interface spq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [spq_pkg::DATA_W-1:0]   front_data;
  logic                                front_valid;
  logic [spq_pkg::COUNT_W-1:0]         entry_count;
  logic [1:0]                          status;

  modport source (output valid, front_data, front_valid, entry_count, status, input ready);
  modport sink   (input valid, front_data, front_valid, entry_count, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/spq_ctrl.sv
// Controller of the sorted priority queue: handshake and request decode.
`default_nettype none

module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  output logic              out_valid,
  input  logic              out_ready,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);

  spq_pkg::state_t state_r;
  spq_pkg::state_t state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode the request and steer the response register
  always_comb begin
    in_ready       = (state_r == spq_pkg::S_IDLE) || out_ready;
    out_valid      = (state_r == spq_pkg::S_HOLD);
    cmd.exec       = in_valid && in_ready;
    cmd.push       = 1'b0;
    cmd.pop        = 1'b0;
    cmd.rsp_status = spq_pkg::ST_OK;
    case (spq_pkg::req_t'(req_type))
      spq_pkg::REQ_PUSH: begin
        cmd.push       = !stat.full;
        cmd.rsp_status = stat.full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
      end
      spq_pkg::REQ_POP: begin
        cmd.pop        = !stat.empty;
        cmd.rsp_status = stat.empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
      end
      default: begin
        cmd.rsp_status = stat.empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
      end
    endcase

    state_nxt = state_r;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (cmd.exec) state_nxt = spq_pkg::S_HOLD;
      end
      spq_pkg::S_HOLD: begin
        if (!cmd.exec && out_ready) state_nxt = spq_pkg::S_IDLE;
      end
      default: state_nxt = spq_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/spq_datapath.sv
// Datapath of the sorted priority queue: sorted cell array and response register.
`default_nettype none

module spq_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spq_pkg::spq_cmd_t                   cmd,
  output spq_pkg::spq_stat_t                  stat,
  input  logic signed [spq_pkg::DATA_W-1:0]   item_data,
  input  logic signed [spq_pkg::DATA_W-1:0]   item_priority,
  output logic signed [spq_pkg::DATA_W-1:0]   front_data,
  output logic                                front_valid,
  output logic [spq_pkg::COUNT_W-1:0]         entry_count,
  output logic [1:0]                          status
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [spq_pkg::DATA_W-1:0] prio_r   [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] data_r   [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] prio_nxt [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] data_nxt [CAPACITY];
  logic [CAPACITY-1:0]               gt;
  logic [CW-1:0]                     cnt_r;
  logic [CW-1:0]                     cnt_nxt;
  logic [CW+spq_pkg::COUNT_W-1:0]    cnt_ext;

  logic signed [spq_pkg::DATA_W-1:0] front_data_r;
  logic                              front_valid_r;
  logic [spq_pkg::COUNT_W-1:0]       entry_count_r;
  spq_pkg::status_t                  status_r;

  // Per cell: compare and pick keep, insert or shift
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign gt[g] = (CW'(g) < cnt_r) && (prio_r[g] > item_priority);

    always_comb begin
      prio_nxt[g] = prio_r[g];
      data_nxt[g] = data_r[g];
      if (cmd.push) begin
        if (!gt[g]) begin
          if (g == 0) begin
            prio_nxt[g] = item_priority;
            data_nxt[g] = item_data;
          end else if (gt[(g == 0) ? 0 : g-1]) begin
            prio_nxt[g] = item_priority;
            data_nxt[g] = item_data;
          end else begin
            prio_nxt[g] = prio_r[(g == 0) ? 0 : g-1];
            data_nxt[g] = data_r[(g == 0) ? 0 : g-1];
          end
        end
      end else if (cmd.pop) begin
        if (g < CAPACITY-1) begin
          prio_nxt[g] = prio_r[(g < CAPACITY-1) ? g+1 : g];
          data_nxt[g] = data_r[(g < CAPACITY-1) ? g+1 : g];
        end
      end
    end
  end

  // Advance the count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    cnt_ext = {{spq_pkg::COUNT_W{1'b0}}, cnt_nxt};
  end

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(CAPACITY));

  // Hold the cell array
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        prio_r[i] <= prio_nxt[i];
        data_r[i] <= data_nxt[i];
      end
    end
  end

  // Hold the count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Load the response register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      front_valid_r <= (cnt_nxt != '0);
      front_data_r  <= (cnt_nxt != '0) ? data_nxt[0] : spq_pkg::EMPTY_DATA;
      entry_count_r <= cnt_ext[spq_pkg::COUNT_W-1:0];
      status_r      <= cmd.rsp_status;
    end
  end

  assign front_data  = front_data_r;
  assign front_valid = front_valid_r;
  assign entry_count = entry_count_r;
  assign status      = status_r;

endmodule

`default_nettype wire

FILE: hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue.
//
//   channel   modport  carries
//   in_req    sink     req_type, item_data, item_priority
//   out_rsp   source   front_data, front_valid, entry_count, status
//
// One request per cycle unless stalled by out_rsp: the whole cell array
// compares against the new priority in parallel and shifts in the same cycle
// the request is taken. Its response is registered for the next cycle.
// A new request is taken while the response waits if out_rsp.ready is high.
// Synchronous active-low reset empties the queue; the cells are not cleared.
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_req,
  spq_out_if.source  out_rsp
);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t stat;
  logic [1:0]         dp_status;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .req_type  (in_req.req_type),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .item_data     (in_req.item_data),
    .item_priority (in_req.item_priority),
    .front_data    (out_rsp.front_data),
    .front_valid   (out_rsp.front_valid),
    .entry_count   (out_rsp.entry_count),
    .status        (dp_status)
  );

  assign out_rsp.status = dp_status;

endmodule

`default_nettype wire
